### rtl/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;

  localparam logic [1:0] KIND_SIGNED = 2'd0;
  localparam logic [1:0] KIND_HEX    = 2'd1;

  localparam logic [6:0] ASCII_MINUS   = 7'h2d;
  localparam logic [6:0] ASCII_ZERO    = 7'h30;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;

  typedef struct packed {
    logic load;   // capture input transaction
    logic shift;  // one conversion step, two bits in
    logic count;  // find the leading digit
    logic emit;   // push one character to the output register
  } itoa_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic slot_free;
    logic final_char;
  } itoa_sts_t;

  function automatic logic [6:0] ascii_of(input logic [3:0] digit);
    logic [6:0] c;
    if (digit < 4'd10) begin
      c = ASCII_ZERO + {3'd0, digit};
    end else begin
      c = ASCII_LOWER_A + {3'd0, digit - 4'd10};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/itoa_ctrl.sv
`default_nettype none

module itoa_ctrl
  import itoa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      num_valid,
  output logic           num_stall,
  input  itoa_sts_t      sts,
  output itoa_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CONV  = 4'b0010,
    S_COUNT = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign num_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (num_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (sts.conv_done) begin
          state_next = S_COUNT;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_COUNT: begin
        cmd.count  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.final_char) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/itoa_datapath.sv
`default_nettype none

module itoa_datapath
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  itoa_cmd_t                         cmd,
  output itoa_sts_t                         sts,
  input  wire logic [1:0]                   kind,
  input  wire logic signed [VALUE_BITS-1:0] value,
  output logic                              chr_valid,
  input  wire logic                         chr_stall,
  output logic [6:0]                        character,
  output logic                              last
);

  // decimal digits of the widest unsigned value: floor(bits * log10(2)) + 1
  localparam int DIGITS    = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BCD_BITS  = DIGITS * 4;
  localparam int EVEN_BITS = VALUE_BITS + (VALUE_BITS % 2);
  localparam int STEPS     = EVEN_BITS / 2;
  localparam int STEP_W    = $clog2(STEPS + 1);
  localparam int IDX_W     = $clog2(DIGITS);

  logic [EVEN_BITS-1:0] mag;
  logic [BCD_BITS-1:0]  bcd;
  logic [STEP_W-1:0]    step_cnt;
  logic [IDX_W-1:0]     idx;
  logic                 neg;
  logic                 sign_left;

  logic [VALUE_BITS-1:0] pat;
  logic                  is_neg;
  logic [VALUE_BITS-1:0] mag_in;
  logic [BCD_BITS-1:0]   adj_a, sh_a, adj_b, sh_b;
  logic [IDX_W-1:0]      top_idx;
  logic [3:0]            cur_digit;

  assign pat    = value;
  assign is_neg = (kind == KIND_SIGNED) && pat[VALUE_BITS-1];
  assign mag_in = is_neg ? VALUE_BITS'(~pat + 1'b1) : pat;

  // double dabble, two bits per step
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj_a[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
    sh_a = {adj_a[BCD_BITS-2:0], mag[EVEN_BITS-1]};
    for (int i = 0; i < DIGITS; i++) begin
      adj_b[i*4 +: 4] = (sh_a[i*4 +: 4] >= 4'd5) ? sh_a[i*4 +: 4] + 4'd3 : sh_a[i*4 +: 4];
    end
    sh_b = {adj_b[BCD_BITS-2:0], mag[EVEN_BITS-2]};
  end

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd[{idx, 2'b00} +: 4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= EVEN_BITS'(mag_in);
      neg <= is_neg;
      if (kind == KIND_HEX) begin
        bcd      <= BCD_BITS'(pat);
        step_cnt <= '0;
      end else begin
        bcd      <= '0;
        step_cnt <= STEP_W'(STEPS);
      end
    end else if (cmd.shift) begin
      bcd      <= sh_b;
      mag      <= {mag[EVEN_BITS-3:0], 2'b00};
      step_cnt <= step_cnt - 1'b1;
    end
    if (cmd.count) begin
      idx       <= top_idx;
      sign_left <= neg;
    end else if (cmd.emit) begin
      if (sign_left) begin
        sign_left <= 1'b0;
        character <= ASCII_MINUS;
        last      <= 1'b0;
      end else begin
        idx       <= idx - 1'b1;
        character <= ascii_of(cur_digit);
        last      <= (idx == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (cmd.emit) begin
      chr_valid <= 1'b1;
    end else if (!chr_stall) begin
      chr_valid <= 1'b0;
    end
  end

  assign sts.conv_done  = (step_cnt == '0);
  assign sts.slot_free  = !chr_valid || !chr_stall;
  assign sts.final_char = !sign_left && (idx == '0);

endmodule

`default_nettype wire

### rtl/integer_to_ascii_converter_core.sv
`default_nettype none

// Channel  Handshake              Payload
// num      num_valid / num_stall  kind[1:0], value[VALUE_BITS-1:0]
// chr      chr_valid / chr_stall  character[6:0], last
//
// One number at a time. Decimal: a load, VALUE_BITS/2 (rounded up) steps
// of the two-bit double dabble loop, a settle step and a search for the
// leading digit, then one character per cycle (sign plus digits) while chr_stall
// allows. Hex skips the conversion loop. num_stall drops once the last
// character is in the output register. Reset is synchronous; chr_stall only
// holds up emission.
module integer_to_ascii_converter_core
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         num_valid,
  output logic                              num_stall,
  input  wire logic [1:0]                   kind,
  input  wire logic signed [VALUE_BITS-1:0] value,
  output logic                              chr_valid,
  input  wire logic                         chr_stall,
  output logic [6:0]                        character,
  output logic                              last
);

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_stall (num_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  itoa_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .kind      (kind),
    .value     (value),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .character (character),
    .last      (last)
  );

endmodule

`default_nettype wire
